FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// expects clock and reset signals in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/xyzlab_pkg.sv
// shared types, constants and white-point tables for the xyz to cielab converter
// no dependencies
package xyzlab_pkg;

   localparam int FRAC_BITS = 8;
   localparam int IN_W      = 15;
   localparam int L_W       = 15;
   localparam int A_W       = 18;
   localparam int B_W       = 17;
   localparam int ILLUM_W   = 5;
   localparam int NUM_WHITES = 20;
   localparam logic [ILLUM_W-1:0] DEFAULT_ILLUM = 5'd5;

   localparam int LANES  = 3;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   localparam int RECIP_W = 19;
   localparam int PROD_W  = IN_W + RECIP_W;
   localparam int T_W     = PROD_W - FRAC_BITS;
   localparam int CELLS   = 20;
   localparam int N_W     = 3 * CELLS;
   localparam int N_SHIFT = 24;
   localparam int ROOT_W  = 20;
   localparam int SQ_W    = 2 * ROOT_W;
   localparam int REM_W   = SQ_W + 6;
   localparam int LIN_T_W = 18;
   localparam int LP_W    = LIN_T_W + RECIP_W + 1;
   localparam int LIN_W   = 15;
   localparam int W_W     = 36;
   localparam int RND_SHIFT = 16 - FRAC_BITS;

   localparam longint SCALE = 64'd167772160000;

   localparam logic [RECIP_W-1:0] RECIP_X [NUM_WHITES] = '{
      RECIP_W'((SCALE + 1098500/2) / 1098500), RECIP_W'((SCALE + 990927/2) / 990927),
      RECIP_W'((SCALE + 980740/2) / 980740),   RECIP_W'((SCALE + 964220/2) / 964220),
      RECIP_W'((SCALE + 956820/2) / 956820),   RECIP_W'((SCALE + 950470/2) / 950470),
      RECIP_W'((SCALE + 949720/2) / 949720),   RECIP_W'((SCALE + 1000000/2) / 1000000),
      RECIP_W'((SCALE + 928340/2) / 928340),   RECIP_W'((SCALE + 991870/2) / 991870),
      RECIP_W'((SCALE + 1037540/2) / 1037540), RECIP_W'((SCALE + 1091470/2) / 1091470),
      RECIP_W'((SCALE + 908720/2) / 908720),   RECIP_W'((SCALE + 973090/2) / 973090),
      RECIP_W'((SCALE + 950440/2) / 950440),   RECIP_W'((SCALE + 964130/2) / 964130),
      RECIP_W'((SCALE + 1003650/2) / 1003650), RECIP_W'((SCALE + 961740/2) / 961740),
      RECIP_W'((SCALE + 1009660/2) / 1009660), RECIP_W'((SCALE + 1080460/2) / 1080460)
   };

   localparam logic [RECIP_W-1:0] RECIP_Z [NUM_WHITES] = '{
      RECIP_W'((SCALE + 355850/2) / 355850),   RECIP_W'((SCALE + 853130/2) / 853130),
      RECIP_W'((SCALE + 1182320/2) / 1182320), RECIP_W'((SCALE + 825210/2) / 825210),
      RECIP_W'((SCALE + 921490/2) / 921490),   RECIP_W'((SCALE + 1088830/2) / 1088830),
      RECIP_W'((SCALE + 1226380/2) / 1226380), RECIP_W'((SCALE + 1000000/2) / 1000000),
      RECIP_W'((SCALE + 1036650/2) / 1036650), RECIP_W'((SCALE + 673950/2) / 673950),
      RECIP_W'((SCALE + 498610/2) / 498610),   RECIP_W'((SCALE + 388130/2) / 388130),
      RECIP_W'((SCALE + 987230/2) / 987230),   RECIP_W'((SCALE + 601910/2) / 601910),
      RECIP_W'((SCALE + 1087550/2) / 1087550), RECIP_W'((SCALE + 823330/2) / 823330),
      RECIP_W'((SCALE + 678680/2) / 678680),   RECIP_W'((SCALE + 817120/2) / 817120),
      RECIP_W'((SCALE + 643700/2) / 643700),   RECIP_W'((SCALE + 392280/2) / 392280)
   };

   localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'((SCALE + 1000000/2) / 1000000);

   localparam logic [T_W-1:0]     T_KNEE     = T_W'(148578);
   localparam logic [RECIP_W-1:0] LIN_SLOPE  = RECIP_W'(510329);
   localparam logic [LIN_W-1:0]   LIN_OFFSET = LIN_W'(9039);
   localparam logic [LP_W-1:0]    LIN_ROUND  = LP_W'(64'd1 << 23);

   typedef struct packed {
      logic [T_W-1:0]    t;
      logic [LIN_W-1:0]  lin;
      logic              knee;
      logic [ROOT_W-1:0] root;
      logic [SQ_W-1:0]   sq;
      logic [REM_W-1:0]  rem;
   } lane_type;

   typedef struct packed {
      logic                      valid;
      lane_type [LANES-1:0]      lane;
   } stage_type;

endpackage

FILE: rtl/xyzlab_front.sv
// front end: white reciprocal select, ratio multiply and linear branch
// depends on xyzlab_pkg
module xyzlab_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [xyzlab_pkg::IN_W-1:0]        x_in,
   input  logic [xyzlab_pkg::IN_W-1:0]        y_in,
   input  logic [xyzlab_pkg::IN_W-1:0]        z_in,
   input  logic [xyzlab_pkg::ILLUM_W-1:0]     illum,
   output xyzlab_pkg::stage_type              chain_out
);

   logic [xyzlab_pkg::ILLUM_W-1:0] sel;
   logic [xyzlab_pkg::RECIP_W-1:0] recip_in [xyzlab_pkg::LANES];
   logic [xyzlab_pkg::IN_W-1:0]    v_in [xyzlab_pkg::LANES];

   logic                           valid0_ff, valid1_ff, valid2_ff;
   logic [xyzlab_pkg::IN_W-1:0]    v_ff [xyzlab_pkg::LANES];
   logic [xyzlab_pkg::RECIP_W-1:0] recip_ff [xyzlab_pkg::LANES];
   logic [xyzlab_pkg::T_W-1:0]     t1_ff [xyzlab_pkg::LANES];
   logic [xyzlab_pkg::T_W-1:0]     t2_ff [xyzlab_pkg::LANES];
   logic [xyzlab_pkg::LP_W-1:0]    lp_ff [xyzlab_pkg::LANES];
   xyzlab_pkg::stage_type          stage_ff;

   always_comb begin
      // unlisted illuminants fall back to d65
      sel = (illum < xyzlab_pkg::ILLUM_W'(xyzlab_pkg::NUM_WHITES)) ? illum
                                                                  : xyzlab_pkg::DEFAULT_ILLUM;
      recip_in[xyzlab_pkg::LANE_X] = xyzlab_pkg::RECIP_X[sel];
      recip_in[xyzlab_pkg::LANE_Y] = xyzlab_pkg::RECIP_Y;
      recip_in[xyzlab_pkg::LANE_Z] = xyzlab_pkg::RECIP_Z[sel];
      v_in[xyzlab_pkg::LANE_X] = x_in;
      v_in[xyzlab_pkg::LANE_Y] = y_in;
      v_in[xyzlab_pkg::LANE_Z] = z_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else begin
         valid0_ff <= accept;
         valid1_ff <= valid0_ff;
         valid2_ff <= valid1_ff;
         stage_ff.valid <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < xyzlab_pkg::LANES; i++) begin
         logic [xyzlab_pkg::PROD_W-1:0] prod;
         logic [xyzlab_pkg::LP_W-1:0]   lsum;
         prod = xyzlab_pkg::PROD_W'(v_ff[i]) * xyzlab_pkg::PROD_W'(recip_ff[i]);
         lsum = lp_ff[i] + xyzlab_pkg::LIN_ROUND;
         v_ff[i]     <= v_in[i];
         recip_ff[i] <= recip_in[i];
         t1_ff[i]    <= prod[xyzlab_pkg::FRAC_BITS +: xyzlab_pkg::T_W];
         t2_ff[i]    <= t1_ff[i];
         lp_ff[i]    <= xyzlab_pkg::LP_W'(t1_ff[i][xyzlab_pkg::LIN_T_W-1:0])
                        * xyzlab_pkg::LP_W'(xyzlab_pkg::LIN_SLOPE);
         stage_ff.lane[i].t    <= t2_ff[i];
         stage_ff.lane[i].knee <= (t2_ff[i] > xyzlab_pkg::T_KNEE);
         stage_ff.lane[i].lin  <= xyzlab_pkg::LIN_W'(lsum >> 24) + xyzlab_pkg::LIN_OFFSET;
         stage_ff.lane[i].root <= '0;
         stage_ff.lane[i].sq   <= '0;
         stage_ff.lane[i].rem  <= '0;
      end
   end

   assign chain_out = stage_ff;

endmodule

FILE: rtl/xyzlab_cell.sv
// one cell of the cube root chain: settles one root bit per lane
// depends on xyzlab_pkg
module xyzlab_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  xyzlab_pkg::stage_type                 d_in,
   input  logic [xyzlab_pkg::LANES-1:0][2:0]     grp,
   output xyzlab_pkg::stage_type                 d_out
);

   xyzlab_pkg::stage_type stage_ff;
   xyzlab_pkg::stage_type stage_in;

   always_comb begin
      stage_in = d_in;
      for (int i = 0; i < xyzlab_pkg::LANES; i++) begin
         logic [xyzlab_pkg::REM_W-1:0] x, d, sq_e, root_e;
         x      = {d_in.lane[i].rem[xyzlab_pkg::REM_W-4:0], grp[i]};
         sq_e   = xyzlab_pkg::REM_W'(d_in.lane[i].sq);
         root_e = xyzlab_pkg::REM_W'(d_in.lane[i].root);
         // (2r+1)^3 - 8r^3 = 12r^2 + 6r + 1
         d = (sq_e << 3) + (sq_e << 2) + (root_e << 2) + (root_e << 1) + 1'b1;
         if (x >= d) begin
            stage_in.lane[i].rem  = x - d;
            stage_in.lane[i].root = {d_in.lane[i].root[xyzlab_pkg::ROOT_W-2:0], 1'b1};
            stage_in.lane[i].sq   = (d_in.lane[i].sq << 2)
                                    + (xyzlab_pkg::SQ_W'(d_in.lane[i].root) << 2) + 1'b1;
         end else begin
            stage_in.lane[i].rem  = x;
            stage_in.lane[i].root = {d_in.lane[i].root[xyzlab_pkg::ROOT_W-2:0], 1'b0};
            stage_in.lane[i].sq   = d_in.lane[i].sq << 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff.lane <= stage_in.lane;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= d_in.valid;
      end
   end

   assign d_out = stage_ff;

endmodule

FILE: rtl/xyzlab_back.sv
// back end: branch select, lab combine, rounding and saturation
// depends on xyzlab_pkg
module xyzlab_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  xyzlab_pkg::stage_type                d_in,
   output logic                                 out_valid,
   output logic [xyzlab_pkg::L_W-1:0]           lightness,
   output logic signed [xyzlab_pkg::A_W-1:0]    green_red,
   output logic signed [xyzlab_pkg::B_W-1:0]    blue_yellow
);

   localparam logic signed [xyzlab_pkg::W_W-1:0] HALF =
      xyzlab_pkg::W_W'((64'd1 << xyzlab_pkg::RND_SHIFT) >> 1);

   logic signed [xyzlab_pkg::W_W-1:0] f [xyzlab_pkg::LANES];
   logic signed [xyzlab_pkg::W_W-1:0] l_in, a_in, b_in;
   logic signed [xyzlab_pkg::W_W-1:0] l_ff, a_ff, b_ff;
   logic signed [xyzlab_pkg::W_W-1:0] l_r, a_r, b_r;
   logic                              comb_valid_ff, out_valid_ff;
   logic [xyzlab_pkg::L_W-1:0]        l_out_ff;
   logic signed [xyzlab_pkg::A_W-1:0] a_out_ff;
   logic signed [xyzlab_pkg::B_W-1:0] b_out_ff;

   always_comb begin
      for (int i = 0; i < xyzlab_pkg::LANES; i++) begin
         f[i] = d_in.lane[i].knee
                ? signed'(xyzlab_pkg::W_W'(d_in.lane[i].root))
                : signed'(xyzlab_pkg::W_W'(d_in.lane[i].lin));
      end
      l_in = f[xyzlab_pkg::LANE_Y] * 36'sd116 - 36'sd1048576;
      a_in = (f[xyzlab_pkg::LANE_X] - f[xyzlab_pkg::LANE_Y]) * 36'sd500;
      b_in = (f[xyzlab_pkg::LANE_Y] - f[xyzlab_pkg::LANE_Z]) * 36'sd200;
      // round half up, then drop the extra fraction bits
      l_r = (l_ff + HALF) >>> xyzlab_pkg::RND_SHIFT;
      a_r = (a_ff + HALF) >>> xyzlab_pkg::RND_SHIFT;
      b_r = (b_ff + HALF) >>> xyzlab_pkg::RND_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comb_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         comb_valid_ff <= d_in.valid;
         out_valid_ff  <= comb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      l_ff <= l_in;
      a_ff <= a_in;
      b_ff <= b_in;
      priority if (l_r < 36'sd0)         l_out_ff <= '0;
      else if (l_r > 36'sd32767)         l_out_ff <= '1;
      else                               l_out_ff <= l_r[xyzlab_pkg::L_W-1:0];
      priority if (a_r < -36'sd131072)   a_out_ff <= {1'b1, {(xyzlab_pkg::A_W-1){1'b0}}};
      else if (a_r > 36'sd131071)        a_out_ff <= {1'b0, {(xyzlab_pkg::A_W-1){1'b1}}};
      else                               a_out_ff <= a_r[xyzlab_pkg::A_W-1:0];
      priority if (b_r < -36'sd65536)    b_out_ff <= {1'b1, {(xyzlab_pkg::B_W-1){1'b0}}};
      else if (b_r > 36'sd65535)         b_out_ff <= {1'b0, {(xyzlab_pkg::B_W-1){1'b1}}};
      else                               b_out_ff <= b_r[xyzlab_pkg::B_W-1:0];
   end

   assign out_valid   = out_valid_ff;
   assign lightness   = l_out_ff;
   assign green_red   = a_out_ff;
   assign blue_yellow = b_out_ff;

endmodule

FILE: rtl/xyz_to_cielab.sv
// cie xyz to cielab converter, top level
// depends on xyzlab_pkg, xyzlab_front, xyzlab_cell, xyzlab_back, assert_macros.svh
//
// usage:
//   req_ channel: present x, y, z (unsigned q7.8) with start; the colour is
//   transferred at an edge where start is high and busy is low. busy is only
//   high during reset, so one colour can be transferred every cycle.
//   rsp_ channel: rsp_valid strobes for one cycle with l*, a*, b*; results
//   come out in transfer order and the receiver cannot stall them.
//   csr_ channel: csr_valid/csr_ready write of the illuminant index; ready is
//   always high. write only while no colour is in flight.
// pipeline from transfer to strobe: four front stages (white reciprocal,
//   ratio multiply, linear branch), twenty cube root cells, each settling
//   one root bit, and two back stages (combine, round/saturate).
// throughput: one colour per cycle outside reset, fixed by the fully pipelined chain.
// reset: clears every stage valid and sets the illuminant to d65; colours in
//   flight are dropped.
`include "assert_macros.svh"

module xyz_to_cielab (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [xyzlab_pkg::IN_W-1:0]           req_x_in,
   input  logic [xyzlab_pkg::IN_W-1:0]           req_y_in,
   input  logic [xyzlab_pkg::IN_W-1:0]           req_z_in,
   output logic                                  rsp_valid,
   output logic [xyzlab_pkg::L_W-1:0]            rsp_lightness,
   output logic signed [xyzlab_pkg::A_W-1:0]     rsp_green_red,
   output logic signed [xyzlab_pkg::B_W-1:0]     rsp_blue_yellow,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [xyzlab_pkg::ILLUM_W-1:0]        csr_illuminant
);

   logic                            accept;
   logic [xyzlab_pkg::ILLUM_W-1:0]  illum_ff;
   xyzlab_pkg::stage_type           chain [xyzlab_pkg::CELLS+1];

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         illum_ff <= xyzlab_pkg::DEFAULT_ILLUM;
      end else if (csr_valid && csr_ready) begin
         illum_ff <= csr_illuminant;
      end
   end

   xyzlab_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .x_in      (req_x_in),
      .y_in      (req_y_in),
      .z_in      (req_z_in),
      .illum     (illum_ff),
      .chain_out (chain[0])
   );

   for (genvar k = 0; k < xyzlab_pkg::CELLS; k++) begin : g_cell
      logic [xyzlab_pkg::LANES-1:0][2:0] grp;
      for (genvar j = 0; j < xyzlab_pkg::LANES; j++) begin : g_lane
         logic [xyzlab_pkg::N_W-1:0] n;
         // radicand is the ratio scaled up by 2^24, taken three bits per cell
         assign n = xyzlab_pkg::N_W'({chain[k].lane[j].t, {xyzlab_pkg::N_SHIFT{1'b0}}});
         assign grp[j] = n[xyzlab_pkg::N_W-1-3*k -: 3];
      end
      xyzlab_cell u_cell (
         .clock (clock),
         .reset (reset),
         .d_in  (chain[k]),
         .grp   (grp),
         .d_out (chain[k+1])
      );
   end

   xyzlab_back u_back (
      .clock       (clock),
      .reset       (reset),
      .d_in        (chain[xyzlab_pkg::CELLS]),
      .out_valid   (rsp_valid),
      .lightness   (rsp_lightness),
      .green_red   (rsp_green_red),
      .blue_yellow (rsp_blue_yellow)
   );

   `ASSERT_IMPLY(a_clear_after_reset, $past(reset), !rsp_valid && !chain[0].valid, "pipeline not cleared by reset")
   `ASSERT_IMPLY(a_illum_hold, !$past(reset) && !$past(csr_valid), $stable(illum_ff), "illuminant changed without a write")
   `ASSERT_IMPLY(a_back_latency, rsp_valid, $past(chain[xyzlab_pkg::CELLS].valid, 2), "result strobe without a finished root")

endmodule
